>>> rtl/apc_pkg.sv
// Shared types, constants and a helper function of the peak compressor.
`default_nettype none
package apc_pkg;

  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEFF_BITS_DEF      = 16;
  localparam int LOG_TABLE_DEPTH_DEF = 256;

  localparam int ACC_W = 64;

  // dB per octave split as 6*2^16 + 1350 so it fits the narrow operand
  localparam int DB_OCT_HI  = 6;
  localparam int DB_OCT_LO  = 1350;
  localparam int OCT_PER_DB = 10885;

  localparam int THR_MIN    = -15360;
  localparam int SLOPE_MAX  = 62259;
  localparam int MAKEUP_MAX = 10240;
  localparam int WET_MAX    = 65536;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_SLOPE     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_WET       = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_8  = 2'd1,
    SH_16 = 2'd2
  } sh_e;

  typedef struct packed {
    logic en;
    logic load;
    sh_e  sh;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [14:0] thr;
    logic [15:0]        slope;
    logic [13:0]        makeup;
    logic [16:0]        wet;
  } cfg_t;

  // bit-pair integer square root, fixed iteration count
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] rem;
    r   = '0;
    bt  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/apc_cfg_regs.sv
// Configuration registers with range clamping.
`default_nettype none
module apc_cfg_regs #(
  parameter int COEFF_BITS = 16,
  parameter int CW         = 16,
  parameter int DW         = 17
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [DW-1:0]         cfg_wdata_i,
  output apc_pkg::cfg_t              cfg_o,
  output logic      [COEFF_BITS:0]   attack_o,
  output logic      [COEFF_BITS:0]   release_o
);
  import apc_pkg::*;

  localparam logic [CW:0] ONE = (CW+1)'(1) << COEFF_BITS;

  logic signed [14:0] thr_q;
  logic [15:0]        slope_q;
  logic [CW-1:0]      att_q;
  logic [CW-1:0]      rel_q;
  logic [13:0]        makeup_q;
  logic [16:0]        wet_q;
  logic [CW-1:0]      cmask_w;

  assign cmask_w = CW'(DW'(cfg_wdata_i) & DW'((DW'(1) << COEFF_BITS) - DW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= -15'sd3072;
      slope_q  <= 16'd49152;
      att_q    <= CW'(65000);
      rel_q    <= CW'(65500);
      makeup_q <= '0;
      wet_q    <= 17'd65536;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_THRESHOLD: thr_q    <= cfg_wdata_i[14:0];
        REG_SLOPE:     slope_q  <= cfg_wdata_i[15:0];
        REG_ATTACK:    att_q    <= cmask_w;
        REG_RELEASE:   rel_q    <= cmask_w;
        REG_MAKEUP:    makeup_q <= cfg_wdata_i[13:0];
        REG_WET:       wet_q    <= cfg_wdata_i[16:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (thr_q < 15'(THR_MIN)) cfg_o.thr = 15'(THR_MIN);
    else if (thr_q > 15'sd0)  cfg_o.thr = '0;
    else                      cfg_o.thr = thr_q;
    cfg_o.slope  = (slope_q > 16'(SLOPE_MAX))   ? 16'(SLOPE_MAX)  : slope_q;
    cfg_o.makeup = (makeup_q > 14'(MAKEUP_MAX)) ? 14'(MAKEUP_MAX) : makeup_q;
    cfg_o.wet    = (wet_q > 17'(WET_MAX))       ? 17'(WET_MAX)    : wet_q;
  end

  // reset coefficients can exceed unity at narrow coefficient widths
  assign attack_o  = ({1'b0, att_q} > ONE) ? (COEFF_BITS+1)'(ONE)
                                           : (COEFF_BITS+1)'({1'b0, att_q});
  assign release_o = ({1'b0, rel_q} > ONE) ? (COEFF_BITS+1)'(ONE)
                                           : (COEFF_BITS+1)'({1'b0, rel_q});

endmodule
`default_nettype wire

>>> rtl/apc_mac.sv
// Shared multiply-accumulate unit with a selectable product shift.
`default_nettype none
module apc_mac #(
  parameter int MA = 41,
  parameter int MB = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire apc_pkg::mac_ctl_t            ctl_i,
  input  wire logic signed [MA-1:0]         a_i,
  input  wire logic signed [MB-1:0]         b_i,
  output logic signed [apc_pkg::ACC_W-1:0]  acc_o
);
  import apc_pkg::*;

  logic signed [MA+MB-1:0]  prod_w;
  logic signed [ACC_W-1:0]  p64_w;
  logic signed [ACC_W-1:0]  psh_w;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic                     busy_q;

  assign prod_w = a_i * b_i;
  assign p64_w  = ACC_W'(prod_w);

  always_comb begin
    unique case (ctl_i.sh)
      SH_8:    psh_w = p64_w <<< 8;
      SH_16:   psh_w = p64_w <<< 16;
      default: psh_w = p64_w;
    endcase
    acc_d = (ctl_i.load ? '0 : acc_q) + psh_w;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) acc_q <= acc_d;
  end

  // marks that the accumulator has been loaded since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                     busy_q <= 1'b0;
    else if (ctl_i.en && ctl_i.load) busy_q <= 1'b1;
  end

  assign acc_o = busy_q ? acc_q : '0;

endmodule
`default_nettype wire

>>> rtl/audio_peak_compressor.sv
// Top level: sequencer and datapath of the hard-knee peak compressor.
// Sequence per sample: envelope, 5-step normaliser, log, dB, reduction, gain, exp, mix and
//   output states; without gain reduction the reduction states are skipped, and at a zero
//   envelope everything from the normaliser to the reduction. A new sample is taken only
//   after the last one has reached the output register; the shared MAC and the normaliser
//   set the pace, plus any time the output register waits for the sink.
// The next sample is taken while a result waits in the output register.
// Reset: asynchronous, active low; envelope cleared, registers to their defaults.
`default_nettype none
module audio_peak_compressor #(
  parameter int SAMPLE_BITS     = apc_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS      = apc_pkg::COEFF_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = apc_pkg::LOG_TABLE_DEPTH_DEF,
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int CW  = (COEFF_BITS > 16) ? COEFF_BITS : 16,
  localparam int DW  = (CW > 17) ? CW : 17
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [DW-1:0]  cfg_wdata_i,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire logic [TDW-1:0] s_axis_tdata_i,   // sample_in
  input  wire logic           s_axis_tlast_i,   // block_last
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [TDW-1:0]      m_axis_tdata_o,   // sample_out
  output logic                m_axis_tuser_o,   // clipped
  output logic                m_axis_tlast_o    // block_last_out
);
  import apc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CB    = COEFF_BITS;
  localparam int D     = LOG_TABLE_DEPTH;
  localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
  localparam int MA    = (SB + 17 > 34) ? SB + 17 : 34;
  localparam int MB    = (CB + 2 > 18) ? CB + 2 : 18;
  localparam logic [CB:0] ONE = (CB+1)'(1) << CB;
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  typedef logic [15:0] log_tab_t [LOG_TABLE_DEPTH];
  typedef logic [31:0] exp_tab_t [LOG_TABLE_DEPTH];

  function automatic log_tab_t build_log();
    log_tab_t    t;
    logic [63:0] m;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      m = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          m    = m >> 1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] roots [17];
    logic [63:0] m;
    logic [63:0] f;
    roots[0] = '0;
    roots[1] = isqrt64(64'd2 << 60);
    for (int k = 2; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      f = (64'(i) << 16) / 64'(LOG_TABLE_DEPTH);
      m = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        if (f[16-k]) m = (m * roots[k] + (64'd1 << 29)) >> 30;
      end
      t[i] = m[31:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_ENV1  = 21'h000002,
    S_ENV2  = 21'h000004,
    S_ENV3  = 21'h000008,
    S_NORM  = 21'h000010,
    S_LOG   = 21'h000020,
    S_DB1   = 21'h000040,
    S_DB2   = 21'h000080,
    S_DB3   = 21'h000100,
    S_RED1  = 21'h000200,
    S_RED2  = 21'h000400,
    S_GAIN1 = 21'h000800,
    S_GAIN2 = 21'h001000,
    S_EXP1  = 21'h002000,
    S_EXP2  = 21'h004000,
    S_MIX1  = 21'h008000,
    S_MIX2  = 21'h010000,
    S_MIX3  = 21'h020000,
    S_MIX4  = 21'h040000,
    S_MIX5  = 21'h080000,
    S_OUT   = 21'h100000
  } state_e;

  state_e                  state_q, state_d;
  logic signed [SB-1:0]    x_q, x_d;
  logic                    last_q, last_d;
  logic [31:0]             mag_q, mag_d;
  logic [CB:0]             c_q, c_d;
  logic [31:0]             env_q, env_d;
  logic [31:0]             nrm_q, nrm_d;
  logic [4:0]              lz_q, lz_d;
  logic [2:0]              step_q, step_d;
  logic signed [22:0]      l2_q, l2_d;
  logic [14:0]             over_q, over_d;
  logic signed [16:0]      gain_q, gain_d;
  logic signed [21:0]      g2_q, g2_d;
  logic [31:0]             lin_q, lin_d;
  logic [24:0]             g16_q, g16_d;
  logic signed [MA-1:0]    t_q, t_d;
  logic [SB-1:0]           out_data_q, out_data_d;
  logic                    out_clip_q, out_clip_d;
  logic                    out_last_q, out_last_d;
  logic                    out_valid_q, out_valid_d;

  cfg_t                    cfg_w;
  logic [CB:0]             attack_w, release_w;
  mac_ctl_t                mac_ctl;
  logic signed [MA-1:0]    mac_a;
  logic signed [MB-1:0]    mac_b;
  logic signed [ACC_W-1:0] acc_w;

  logic                    in_acc_w;
  logic signed [SB-1:0]    x_in_w;
  logic [SB-1:0]           abs_w;
  logic [31:0]             mag_in_w;
  logic [ACC_W-1:0]        env_sum_w;
  logic [31:0]             env_new_w;
  logic [4:0]              sh_amt_w;
  logic [43:0]             lidx_prod_w;
  logic [IDX_W-1:0]        lidx_w;
  logic signed [ACC_W-1:0] db_sum_w;
  logic signed [17:0]      env_db_w;
  logic signed [17:0]      over_w;
  logic [ACC_W-1:0]        red_sum_w;
  logic signed [ACC_W-1:0] g2_sum_w;
  logic [28:0]             eidx_prod_w;
  logic [IDX_W-1:0]        eidx_w;
  logic signed [5:0]       ip_w;
  logic [5:0]              neg_ip_w;
  logic [39:0]             lin_sh_w;
  logic [39:0]             g16_sum_w;
  logic signed [ACC_W-1:0] y_w;

  apc_cfg_regs #(
    .COEFF_BITS (CB),
    .CW         (CW),
    .DW         (DW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg_w),
    .attack_o    (attack_w),
    .release_o   (release_w)
  );

  apc_mac #(
    .MA (MA),
    .MB (MB)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc_w)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc_w        = s_axis_tvalid_i && s_axis_tready_o;
  assign x_in_w          = s_axis_tdata_i[SB-1:0];
  assign abs_w           = x_in_w[SB-1] ? SB'(-x_in_w) : SB'(x_in_w);
  assign mag_in_w        = 32'(abs_w) << (32 - SB);

  assign env_sum_w   = acc_w + ACC_W'(ONE >> 1);
  assign env_new_w   = env_sum_w[CB +: 32];
  assign sh_amt_w    = 5'(5'd16 >> step_q);
  assign lidx_prod_w = 44'(nrm_q[30:0]) * 44'(D);
  assign lidx_w      = lidx_prod_w[31 +: IDX_W];
  assign db_sum_w    = acc_w + (ACC_W'(1) <<< 23);
  assign env_db_w    = 18'(db_sum_w >>> 24);
  assign over_w      = env_db_w - 18'(cfg_w.thr);
  assign red_sum_w   = acc_w + ACC_W'(32768);
  assign g2_sum_w    = acc_w + ACC_W'(128);
  assign eidx_prod_w = 29'(g2_q[15:0]) * 29'(D);
  assign eidx_w      = eidx_prod_w[16 +: IDX_W];
  assign ip_w        = g2_q[21:16];
  assign neg_ip_w    = 6'(-ip_w);
  assign lin_sh_w    = ip_w[5] ? (40'(lin_q) >> neg_ip_w) : (40'(lin_q) << ip_w[2:0]);
  assign g16_sum_w   = lin_sh_w + 40'd8192;
  assign y_w         = (acc_w + (ACC_W'(1) <<< 23)) >>> 24;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    last_d      = last_q;
    mag_d       = mag_q;
    c_d         = c_q;
    env_d       = env_q;
    nrm_d       = nrm_q;
    lz_d        = lz_q;
    step_d      = step_q;
    l2_d        = l2_q;
    over_d      = over_q;
    gain_d      = gain_q;
    g2_d        = g2_q;
    lin_d       = lin_q;
    g16_d       = g16_q;
    t_d         = t_q;
    out_data_d  = out_data_q;
    out_clip_d  = out_clip_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    mac_ctl     = '{en: 1'b0, load: 1'b0, sh: SH_0};
    mac_a       = MA'(x_q);
    mac_b       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc_w) begin
          x_d     = x_in_w;
          last_d  = s_axis_tlast_i;
          mag_d   = mag_in_w;
          c_d     = (mag_in_w > env_q) ? attack_w : release_w;
          state_d = S_ENV1;
        end
      end
      S_ENV1: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_0};
        mac_a   = MA'($signed({1'b0, env_q}));
        mac_b   = MB'($signed({1'b0, c_q}));
        state_d = S_ENV2;
      end
      S_ENV2: begin
        mac_ctl = '{en: 1'b1, load: 1'b0, sh: SH_0};
        mac_a   = MA'($signed({1'b0, mag_q}));
        mac_b   = MB'($signed({1'b0, ONE - c_q}));
        state_d = S_ENV3;
      end
      S_ENV3: begin
        env_d  = env_new_w;
        nrm_d  = env_new_w;
        lz_d   = '0;
        step_d = '0;
        if (env_new_w == '0) begin
          gain_d  = 17'($signed({1'b0, cfg_w.makeup}));
          state_d = S_GAIN1;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // binary leading-zero search: 16, 8, 4, 2, 1
        if ((nrm_q >> (6'd32 - 6'(sh_amt_w))) == '0) begin
          nrm_d = nrm_q << sh_amt_w;
          lz_d  = lz_q + sh_amt_w;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) state_d = S_LOG;
      end
      S_LOG: begin
        l2_d    = 23'($signed({1'b0, LOG_TAB[lidx_w]})) - 23'({lz_q, 16'b0});
        state_d = S_DB1;
      end
      S_DB1: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_16};
        mac_a   = MA'(l2_q);
        mac_b   = MB'(DB_OCT_HI);
        state_d = S_DB2;
      end
      S_DB2: begin
        mac_ctl = '{en: 1'b1, load: 1'b0, sh: SH_0};
        mac_a   = MA'(l2_q);
        mac_b   = MB'(DB_OCT_LO);
        state_d = S_DB3;
      end
      S_DB3: begin
        if (over_w > 18'sd0) begin
          over_d  = over_w[14:0];
          state_d = S_RED1;
        end else begin
          gain_d  = 17'($signed({1'b0, cfg_w.makeup}));
          state_d = S_GAIN1;
        end
      end
      S_RED1: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_0};
        mac_a   = MA'($signed({1'b0, over_q}));
        mac_b   = MB'($signed({1'b0, cfg_w.slope}));
        state_d = S_RED2;
      end
      S_RED2: begin
        gain_d  = 17'($signed({1'b0, cfg_w.makeup})) - 17'($signed({1'b0, red_sum_w[31:16]}));
        state_d = S_GAIN1;
      end
      S_GAIN1: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_0};
        mac_a   = MA'(gain_q);
        mac_b   = MB'(OCT_PER_DB);
        state_d = S_GAIN2;
      end
      S_GAIN2: begin
        g2_d    = 22'(g2_sum_w >>> 8);
        state_d = S_EXP1;
      end
      S_EXP1: begin
        lin_d   = EXP_TAB[eidx_w];
        state_d = S_EXP2;
      end
      S_EXP2: begin
        g16_d   = g16_sum_w[38:14];
        state_d = S_MIX1;
      end
      S_MIX1: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_0};
        mac_b   = MB'($signed({1'b0, g16_q[15:0]}));
        state_d = S_MIX2;
      end
      S_MIX2: begin
        mac_ctl = '{en: 1'b1, load: 1'b0, sh: SH_16};
        mac_b   = MB'($signed({1'b0, g16_q[24:16]}));
        state_d = S_MIX3;
      end
      S_MIX3: begin
        t_d     = MA'(acc_w >>> 8);
        state_d = S_MIX4;
      end
      S_MIX4: begin
        mac_ctl = '{en: 1'b1, load: 1'b1, sh: SH_8};
        mac_b   = MB'($signed({1'b0, 17'(17'd65536 - cfg_w.wet)}));
        state_d = S_MIX5;
      end
      S_MIX5: begin
        mac_ctl = '{en: 1'b1, load: 1'b0, sh: SH_0};
        mac_a   = t_q;
        mac_b   = MB'($signed({1'b0, cfg_w.wet}));
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q) begin
          if (y_w > SMAX) begin
            out_data_d = SMAX[SB-1:0];
            out_clip_d = 1'b1;
          end else if (y_w < SMIN) begin
            out_data_d = SMIN[SB-1:0];
            out_clip_d = 1'b1;
          end else begin
            out_data_d = y_w[SB-1:0];
            out_clip_d = 1'b0;
          end
          out_last_d  = last_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    last_q     <= last_d;
    mag_q      <= mag_d;
    c_q        <= c_d;
    nrm_q      <= nrm_d;
    lz_q       <= lz_d;
    l2_q       <= l2_d;
    over_q     <= over_d;
    gain_q     <= gain_d;
    g2_q       <= g2_d;
    lin_q      <= lin_d;
    g16_q      <= g16_d;
    t_q        <= t_d;
    out_data_q <= out_data_d;
    out_clip_q <= out_clip_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDW'(out_data_q);
  assign m_axis_tuser_o  = out_clip_q;
  assign m_axis_tlast_o  = out_last_q;

  // the sequencer is busy for the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_w |=> !s_axis_tready_o)
    else $error("input taken while sample in flight");

  // normaliser leaves the leading one at the top bit
  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOG) |-> nrm_q[31])
    else $error("envelope not normalised");

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (out_data_q == SMAX[SB-1:0] || out_data_q == SMIN[SB-1:0]))
    else $error("clip flag without saturated output");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the peak compressor: directed and random samples checked against a model.
`timescale 1ns / 1ps
module tb_top;
  import apc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;  // sample_in
  logic        s_axis_tlast_i = 1'b0; // block_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // sample_out
  logic        m_axis_tuser_o;       // clipped
  logic        m_axis_tlast_o;       // block_last_out

  audio_peak_compressor dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [23:0] smp;
    logic        clip;
    logic        last;
  } result_t;

  result_t      expected_q[$];
  logic [15:0]  log2_lut[256];
  logic [63:0]  exp2_lut[256];
  logic signed [14:0] m_thr;
  logic [15:0]  m_slope, m_att, m_rel;
  logic [13:0]  m_makeup;
  logic [16:0]  m_wet;
  logic [31:0]  m_env;
  int  errors, n_sent, n_checked, idle_cnt;
  int  src_idle, snk_idle;
  bit  sink_hold, done;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint fdiv(longint v, int s);
    return v >>> s;  // arithmetic shift floors
  endfunction

  task automatic build_luts();
    longint unsigned rt[17];
    longint unsigned m, f;
    logic [15:0] r;
    rt[1] = int_sqrt(64'd2 << 60);
    for (int k = 2; k <= 16; k++) rt[k] = int_sqrt(rt[k-1] << 30);
    for (int i = 0; i < 256; i++) begin
      m = ((64'(256 + i)) << 30) / 256;
      r = 0;
      f = (64'(i) << 16) / 256;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          m = m >> 1;
        end
      end
      log2_lut[i] = r;
      m = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if (f[16-k]) m = (m * rt[k] + (64'd1 << 29)) >> 30;
      exp2_lut[i] = m;
    end
  endtask

  task automatic model_reset();
    m_thr = -15'sd3072; m_slope = 16'd49152; m_att = 16'd65000;
    m_rel = 16'd65500; m_makeup = '0; m_wet = 17'd65536; m_env = '0;
  endtask

  function automatic result_t compress(logic [23:0] din, logic lst);
    result_t res;
    longint x, thr, gdb, g2, ip, fp, acc, y, l2, edb, over;
    longint unsigned mag, env, c, slope, w, lin, g16, frac;
    int p;
    x = longint'(signed'(din));
    mag = longint'(x < 0 ? -x : x) << 8;
    env = m_env;
    c = (mag > env) ? m_att : m_rel;
    env = (c * env + (65536 - c) * mag + 32768) >> 16;
    m_env = env[31:0];
    thr = m_thr;
    if (thr < THR_MIN) thr = THR_MIN;
    if (thr > 0) thr = 0;
    slope = (m_slope > SLOPE_MAX) ? SLOPE_MAX : m_slope;
    gdb = (m_makeup > MAKEUP_MAX) ? MAKEUP_MAX : m_makeup;
    w = (m_wet > WET_MAX) ? WET_MAX : m_wet;
    if (env != 0) begin
      p = 31;
      while (p > 0 && env[p] == 1'b0) p--;
      frac = (env << (31 - p)) & 64'h7FFF_FFFF;
      l2 = longint'(p - 31) * 65536 + log2_lut[(frac * 256) >> 31];
      edb = fdiv(l2 * 394566 + (64'sd1 << 23), 24);
      over = edb - thr;
      if (over > 0) gdb = gdb - longint'((unsigned'(over) * slope + 32768) >> 16);
    end
    g2 = fdiv(gdb * OCT_PER_DB + 128, 8);
    ip = fdiv(g2, 16);
    fp = g2 - ip * 65536;
    lin = exp2_lut[(unsigned'(fp) * 256) >> 16];
    lin = (ip >= 0) ? lin << ip : lin >> (-ip);
    g16 = (lin + 8192) >> 14;
    acc = x * longint'(65536 - w) * 256 + fdiv(x * longint'(g16), 8) * longint'(w);
    y = fdiv(acc + (64'sd1 << 23), 24);
    res.clip = 1'b0;
    if (y > 8388607) begin y = 8388607; res.clip = 1'b1; end
    if (y < -8388608) begin y = -8388608; res.clip = 1'b1; end
    res.smp = y[23:0];
    res.last = lst;
    return res;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD: m_thr = val[14:0];
      REG_SLOPE:     m_slope = val[15:0];
      REG_ATTACK:    m_att = val[15:0];
      REG_RELEASE:   m_rel = val[15:0];
      REG_MAKEUP:    m_makeup = val[13:0];
      REG_WET:       m_wet = val;
      default: ;
    endcase
  endtask

  task automatic program_all(int t, int s, int a, int r, int mk, int wt);
    write_reg(REG_THRESHOLD, 17'(t)); write_reg(REG_SLOPE, 17'(s));
    write_reg(REG_ATTACK, 17'(a));    write_reg(REG_RELEASE, 17'(r));
    write_reg(REG_MAKEUP, 17'(mk));   write_reg(REG_WET, 17'(wt));
  endtask

  // sender: predict on acceptance; valid held across back-to-back requests
  task automatic send_sample(logic [23:0] smp, logic lst);
    if (src_idle > 0)
      while ($urandom_range(99) < src_idle) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid_i <= 1'b1; s_axis_tdata_i <= smp; s_axis_tlast_i <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(compress(smp, lst));
    n_sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (sink_hold) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (m_axis_tdata_o !== e.smp) begin
          $error("sample_out exp %h got %h", e.smp, m_axis_tdata_o); errors++;
        end
        if (m_axis_tuser_o !== e.clip) begin
          $error("clipped exp %b got %b", e.clip, m_axis_tuser_o); errors++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("block_last_out exp %b got %b", e.last, m_axis_tlast_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000 && !done) begin
      $display("audio_peak_compressor test failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [23:0] pts[10] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001,
                             24'hFFFFFF, 24'h400000, 24'hC00000, 24'h7FFFFF,
                             24'h000000, 24'h800000};
    // full scale, zero and small samples of both signs, with defaults
    foreach (pts[i]) send_sample(pts[i], i[0]);
    go_idle();
    // instant coefficients, maximum makeup, lowest threshold
    program_all(-15360, 62259, 0, 0, 10240, 65536);
    for (int i = 0; i < 5; i++) send_sample(pts[i], 1'b1);
    go_idle();
    // out-of-range values get clamped
    program_all(16'h3FFF, 65535, 65535, 65535, 16383, 131071);
    for (int i = 0; i < 5; i++) send_sample(pts[i+5], 1'b0);
    go_idle();
    // all-dry mix
    program_all(0, 0, 65535, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_sample(pts[i], 1'b1);
    go_idle();
  endtask

  task automatic random_burst(int n);
    logic [23:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = $urandom;
        1: s = 24'($signed($urandom_range(2000)) - 1000);
        2: s = $urandom_range(1) ? 24'h7FFFFF - $urandom_range(50) : 24'h800000 + $urandom_range(50);
        default: s = 24'(int'($urandom) >>> $urandom_range(23));
      endcase
      send_sample(s, $urandom_range(7) == 0);
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      program_all(-$urandom_range(15360), $urandom_range(62259), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(10240), $urandom_range(65536));
      random_burst(38);
      go_idle();
    end
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      random_burst(12);
      begin
        repeat (600) @(posedge clk_i);
        sink_hold = 1'b0;
      end
    join
    go_idle();
  endtask

  initial begin
    model_reset();
    build_luts();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    src_idle = 29; snk_idle = 87;
    test_directed();
    test_random();
    src_idle = 87; snk_idle = 29;
    test_random();
    src_idle = 0; snk_idle = 0;
    test_backpressure();
    random_burst(60);
    go_idle();
    done = 1'b1;
    $display("Sent %0d samples, checked %0d results over 16 register settings,", n_sent, n_checked);
    $display("including clamped values, clipping and a long output stall.");
    if (errors == 0 && expected_q.size() == 0) $display("audio_peak_compressor test passed");
    else $display("audio_peak_compressor test failed");
    $finish;
  end
endmodule
